FILE: hw/rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared constants, codes and types of the deadline timer pool.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int unsigned TIMER_COUNT = 8;
  localparam int unsigned SLOT_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [6:0]  IDX_LIMIT   = 7'(TIMER_COUNT);

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_QUERY   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_FREE    = 2'd1;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX  = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic        rd_en;
    slot_t       rd_addr;
    logic        wr_en;
    slot_t       wr_addr;
    logic [31:0] wr_data;
  } ram_req_t;

endpackage

FILE: hw/rtl/dtp_if.sv
// ----------------------------------------------------------------------------
// dtp_if
// Request and response channels of the deadline timer pool.
// ----------------------------------------------------------------------------
interface dtp_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [31:0]       now_us;
  logic [31:0]       duration_us;
  logic signed [7:0] slot_index;

  modport source (output valid, req_type, now_us, duration_us, slot_index, input ready);
  modport sink   (input valid, req_type, now_us, duration_us, slot_index, output ready);
endinterface

interface dtp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] granted_index;
  logic       elapsed;

  modport source (output valid, status, granted_index, elapsed, input ready);
  modport sink   (input valid, status, granted_index, elapsed, output ready);
endinterface

FILE: hw/rtl/dtp_end_ram.sv
// ----------------------------------------------------------------------------
// dtp_end_ram
// End-time store: one write and one registered read per cycle. Entries not
// yet written since reset read as zero.
// ----------------------------------------------------------------------------
module dtp_end_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  dtp_pkg::ram_req_t req,
  output logic [31:0]       rd_data
);

  logic [31:0]                     mem [dtp_pkg::TIMER_COUNT];
  logic [dtp_pkg::TIMER_COUNT-1:0] written_r;
  logic [31:0]                     rd_data_r;
  logic                            rd_written_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_written_r <= written_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_written_r ? rd_data_r : 32'd0;

endmodule

FILE: hw/rtl/deadline_timer_pool.sv
// ----------------------------------------------------------------------------
// deadline_timer_pool
// Pool of one-shot deadline timers: start, query, release and clear.
// ----------------------------------------------------------------------------
//  channel  dir  words
//  in_ch    in   req_type, now_us, duration_us, slot_index
//  out_ch   out  status, granted_index, elapsed
//
//  Each word passes through accept (end-time read issued), then execute
//  (compare, allocate, write back), one result word per request.
//  A new word is taken once the previous result has left or is leaving.
//  Reset is synchronous; end times and active flags read as zero after it.
//  Output stalls hold the result register and block further requests.
// ----------------------------------------------------------------------------
module deadline_timer_pool (
  input logic clk,
  input logic rst_n,
  dtp_req_if.sink   in_ch,
  dtp_rsp_if.source out_ch
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                            state_r;
  logic [1:0]                      req_type_r;
  logic [31:0]                     now_r;
  logic [31:0]                     dur_r;
  logic                            idx_ok_r;
  dtp_pkg::slot_t                  slot_r;
  logic [dtp_pkg::TIMER_COUNT-1:0] active_r;
  logic [dtp_pkg::TIMER_COUNT-1:0] active_nxt;

  logic                            out_valid_r;
  logic [1:0]                      status_r;
  logic [5:0]                      granted_r;
  logic                            elapsed_r;
  logic [1:0]                      status_nxt;
  logic [5:0]                      granted_nxt;
  logic                            elapsed_nxt;

  logic                            accept;
  logic                            idx_ok;
  logic                            exec;
  logic                            any_free;
  dtp_pkg::slot_t                  free_idx;
  dtp_pkg::ram_req_t               ram_req;
  logic [31:0]                     end_time;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign exec        = (state_r == S_EXEC);
  assign idx_ok      = !in_ch.slot_index[7] && (in_ch.slot_index[6:0] < dtp_pkg::IDX_LIMIT);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = dtp_pkg::TIMER_COUNT - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_idx = dtp_pkg::slot_t'(i);
      end
    end
  end
  assign any_free = ~&active_r;

  always_comb begin
    ram_req.rd_en   = accept;
    ram_req.rd_addr = in_ch.slot_index[dtp_pkg::SLOT_W-1:0];
    ram_req.wr_en   = exec && (req_type_r == dtp_pkg::REQ_START) && any_free;
    ram_req.wr_addr = free_idx;
    ram_req.wr_data = now_r + dur_r;
  end

  dtp_end_ram u_end_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (end_time)
  );

  always_comb begin
    status_nxt  = dtp_pkg::ST_OK;
    granted_nxt = 6'd0;
    elapsed_nxt = 1'b0;
    active_nxt  = active_r;
    unique case (req_type_r)
      dtp_pkg::REQ_START: begin
        if (any_free) begin
          active_nxt[free_idx] = 1'b1;
          granted_nxt          = 6'(free_idx);
        end else begin
          status_nxt = dtp_pkg::ST_NO_FREE;
        end
      end
      dtp_pkg::REQ_QUERY: begin
        if (idx_ok_r) begin
          elapsed_nxt = (now_r >= end_time);
        end else begin
          status_nxt  = dtp_pkg::ST_BAD_INDEX;
          elapsed_nxt = 1'b1;
        end
      end
      dtp_pkg::REQ_RELEASE: begin
        if (!idx_ok_r) begin
          status_nxt = dtp_pkg::ST_BAD_INDEX;
        end else if (active_r[slot_r]) begin
          active_nxt[slot_r] = 1'b0;
        end else begin
          status_nxt = dtp_pkg::ST_NOT_ACTIVE;
        end
      end
      dtp_pkg::REQ_CLEAR: begin
        active_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_ch.req_type;
      now_r      <= in_ch.now_us;
      dur_r      <= in_ch.duration_us;
      idx_ok_r   <= idx_ok;
      slot_r     <= in_ch.slot_index[dtp_pkg::SLOT_W-1:0];
    end
    if (exec) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        active_r    <= active_nxt;
        out_valid_r <= 1'b1;
        state_r     <= S_IDLE;
      end else begin
        if (out_valid_r && out_ch.ready) begin
          out_valid_r <= 1'b0;
        end
        if (accept) begin
          state_r <= S_EXEC;
        end
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.granted_index = granted_r;
  assign out_ch.elapsed       = elapsed_r;

`ifndef SYNTHESIS
  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> !out_valid_r)
    else $error("result produced while output register busy");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> exec)
    else $error("accepted word not executed");

  a_start_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (req_type_r == dtp_pkg::REQ_START) && any_free) |=>
      ($countones(active_r) == $countones($past(active_r)) + 1))
    else $error("start did not allocate exactly one slot");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (req_type_r == dtp_pkg::REQ_CLEAR)) |=> (active_r == '0))
    else $error("clear left active slots");
`endif

endmodule

FILE: tb/tb_deadline_timer_pool.sv
// ----------------------------------------------------------------------------
// tb_deadline_timer_pool
// Self-checking bench for the deadline timer pool. The first part is a table
// of requests covering reset state, index extremes, pool full, wrapped
// deadlines, release errors and clear. After it comes a long run of random
// start/query/release/clear traffic. Rows with a typed response are checked
// against it, all other words against an in-bench model of the slot table.
// Both channels idle at random, and long response stalls back the block up.
// ----------------------------------------------------------------------------
module tb_deadline_timer_pool;
  import dtp_pkg::*;

  localparam int unsigned RAND_ITEMS = 1425;
  localparam int unsigned LONG_HOLD  = 300;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [31:0]       now_us;
    logic [31:0]       duration_us;
    logic signed [7:0] slot_index;
  } timer_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] granted_index;
    logic       elapsed;
  } timer_rsp_t;

  typedef struct {
    timer_req_t req;
    bit         typed;
    timer_rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dtp_req_if req_ch ();
  dtp_rsp_if rsp_ch ();

  deadline_timer_pool u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  always #5 clk = ~clk;

  // model of the slot table
  logic [31:0]            pool_end_time [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] pool_active;

  timer_rsp_t  pending_rsp_q [$];
  dir_row_t    dir_tab [$];
  logic [31:0] sim_now_us;
  bit          send_burst;
  bit          recv_burst;
  int unsigned mismatch_count;
  int unsigned rsp_count;
  int unsigned n_grant, n_full, n_bad, n_elapsed, n_not_active;

  function automatic timer_rsp_t predict_timer_rsp(timer_req_t r);
    timer_rsp_t  rsp;
    logic        idx_ok;
    logic        found;
    int unsigned slot;
    rsp    = '0;
    found  = 1'b0;
    idx_ok = !r.slot_index[7] && ({1'b0, r.slot_index[6:0]} < TIMER_COUNT);
    slot   = r.slot_index[6:0];
    case (r.req_type)
      REQ_START: begin
        rsp.status = ST_NO_FREE;
        for (int i = 0; i < TIMER_COUNT && !found; i++) begin
          if (!pool_active[i]) begin
            pool_end_time[i]  = r.now_us + r.duration_us;
            pool_active[i]    = 1'b1;
            rsp.granted_index = 6'(i);
            rsp.status        = ST_OK;
            found             = 1'b1;
          end
        end
      end
      REQ_QUERY: begin
        if (idx_ok) begin
          rsp.elapsed = (r.now_us >= pool_end_time[slot]);
        end else begin
          rsp.status  = ST_BAD_INDEX;
          rsp.elapsed = 1'b1;
        end
      end
      REQ_RELEASE: begin
        if (!idx_ok) begin
          rsp.status = ST_BAD_INDEX;
        end else if (pool_active[slot]) begin
          pool_active[slot] = 1'b0;
        end else begin
          rsp.status = ST_NOT_ACTIVE;
        end
      end
      default: begin
        pool_active = '0;
      end
    endcase
    return rsp;
  endfunction

  function automatic timer_req_t random_req();
    timer_req_t  r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      r.req_type = REQ_START;
    end else if (pick < 70) begin
      r.req_type = REQ_QUERY;
    end else if (pick < 96) begin
      r.req_type = REQ_RELEASE;
    end else begin
      r.req_type = REQ_CLEAR;
    end
    pick = $urandom_range(0, 39);
    if (pick == 0) begin
      sim_now_us = $urandom();
    end else if (pick == 1) begin
      sim_now_us = 32'hFFFF_F000 + $urandom_range(0, 4095);
    end else begin
      sim_now_us = sim_now_us + $urandom_range(0, 400);
    end
    r.now_us      = ($urandom_range(0, 24) == 0) ? $urandom() : sim_now_us;
    r.duration_us = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1500);
    r.slot_index  = ($urandom_range(0, 7) == 0) ? 8'($urandom())
                                                : 8'($urandom_range(0, TIMER_COUNT - 1));
    return r;
  endfunction

  task automatic add_row(logic [1:0] rt, logic [31:0] now, logic [31:0] dur,
                         logic signed [7:0] idx, bit typed = 1'b0,
                         logic [1:0] st = ST_OK, logic [5:0] gi = '0, logic el = 1'b0);
    dir_row_t row;
    row.req   = '{rt, now, dur, idx};
    row.typed = typed;
    row.rsp   = '{st, gi, el};
    dir_tab.push_back(row);
  endtask

  task automatic issue_req(timer_req_t r, bit typed, timer_rsp_t typed_rsp);
    int unsigned gap;
    timer_rsp_t  want;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.req_type;
    req_ch.now_us      <= r.now_us;
    req_ch.duration_us <= r.duration_us;
    req_ch.slot_index  <= r.slot_index;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    want = predict_timer_rsp(r);
    if (r.req_type == REQ_START && want.status == ST_OK) n_grant++;
    pending_rsp_q.push_back(typed ? typed_rsp : want);
  endtask

  initial begin : stimulus
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_CLEAR;
    req_ch.now_us      <= '0;
    req_ch.duration_us <= '0;
    req_ch.slot_index  <= '0;
    for (int i = 0; i < TIMER_COUNT; i++) pool_end_time[i] = '0;
    pool_active    = '0;
    sim_now_us     = 32'h0000_1000;
    send_burst     = 1'b0;
    mismatch_count = 0;

    // reset state, index extremes and error codes
    add_row(REQ_QUERY,   32'h0000_0000, '0, 8'sd0,    1'b1, ST_OK,         '0, 1'b1);
    add_row(REQ_RELEASE, 32'h0000_0000, '0, 8'sd0,    1'b1, ST_NOT_ACTIVE, '0, 1'b0);
    add_row(REQ_QUERY,   32'hFFFF_FFFF, '0, 8'sh80,   1'b1, ST_BAD_INDEX,  '0, 1'b1);
    add_row(REQ_QUERY,   32'h0000_0000, '0, 8'sh7F,   1'b1, ST_BAD_INDEX,  '0, 1'b1);
    add_row(REQ_QUERY,   32'h0000_0000, '0, 8'(TIMER_COUNT), 1'b1, ST_BAD_INDEX, '0, 1'b1);
    add_row(REQ_RELEASE, 32'h0000_0000, '0, -8'sd1,   1'b1, ST_BAD_INDEX,  '0, 1'b0);
    add_row(REQ_RELEASE, 32'h0000_0000, '0, 8'(TIMER_COUNT), 1'b1, ST_BAD_INDEX, '0, 1'b0);
    // end time wraps to all-ones minus one
    add_row(REQ_START,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'sd0, 1'b1, ST_OK, '0, 1'b0);
    add_row(REQ_QUERY,   32'hFFFF_FFFE, '0, 8'sd0);
    add_row(REQ_QUERY,   32'hFFFF_FFFD, '0, 8'sd0);
    // deadline past 2^32 reads as elapsed straight away
    add_row(REQ_START,   32'hFFFF_FF00, 32'h0000_0200, 8'sd0);
    add_row(REQ_QUERY,   32'hFFFF_FF10, '0, 8'sd1);
    // fill the remaining slots
    add_row(REQ_START,   32'h0000_1000, 32'h0000_0000, 8'sd0);
    add_row(REQ_START,   32'h0000_1000, 32'h0000_0001, 8'sd0);
    add_row(REQ_START,   32'h0000_1000, 32'h7FFF_FFFF, 8'sd0);
    add_row(REQ_START,   32'h0000_1000, 32'h8000_0000, 8'sd0);
    add_row(REQ_START,   32'h5555_5555, 32'hAAAA_AAAA, 8'sd0);
    add_row(REQ_START,   32'hAAAA_AAAA, 32'h5555_5555, 8'sd0);
    add_row(REQ_START,   32'h0000_2000, 32'h0000_0010, 8'sd0, 1'b1, ST_NO_FREE, '0, 1'b0);
    add_row(REQ_RELEASE, 32'h0000_2000, '0, 8'sd3,    1'b1, ST_OK,         '0, 1'b0);
    add_row(REQ_START,   32'h0000_2000, 32'h0000_0020, 8'sd0);
    // clear keeps end times, frees every slot
    add_row(REQ_CLEAR,   32'h0000_3000, '0, 8'sd0,    1'b1, ST_OK,         '0, 1'b0);
    add_row(REQ_QUERY,   32'h0000_1001, '0, 8'sd2);
    add_row(REQ_RELEASE, 32'h0000_3000, '0, 8'sd2,    1'b1, ST_NOT_ACTIVE, '0, 1'b0);
    add_row(REQ_START,   32'h0000_3000, 32'h0000_0100, 8'sd0, 1'b1, ST_OK, '0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) issue_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
      issue_req(random_req(), 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests: %0d grants, %0d pool-full, %0d not-active, %0d bad-index",
             rsp_count, n_grant, n_full, n_not_active, n_bad);
    $display("%0d elapsed answers; two long response stalls backed up the request side",
             n_elapsed);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : rsp_sink
    timer_rsp_t  want;
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    rsp_count    = 0;
    recv_burst   = 1'b0;
    n_grant      = 0;
    n_full       = 0;
    n_bad        = 0;
    n_elapsed    = 0;
    n_not_active = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rsp_count == 60 || rsp_count == 900) begin
        stall = LONG_HOLD;
      end else begin
        if (rsp_count % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
        stall = recv_burst ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      rsp_count++;
      if (pending_rsp_q.size() == 0) begin
        $error("response word with nothing outstanding: status %0d", rsp_ch.status);
        mismatch_count++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.granted_index !== want.granted_index) begin
          $error("granted_index: expected %0d, got %0d", want.granted_index,
                 rsp_ch.granted_index);
          mismatch_count++;
        end
        if (rsp_ch.elapsed !== want.elapsed) begin
          $error("elapsed: expected %0d, got %0d", want.elapsed, rsp_ch.elapsed);
          mismatch_count++;
        end
        case (want.status)
          ST_NO_FREE:    n_full++;
          ST_NOT_ACTIVE: n_not_active++;
          ST_BAD_INDEX:  n_bad++;
          default:       ;
        endcase
        if (want.elapsed) n_elapsed++;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d response words outstanding", pending_rsp_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
